// File: rtl/par_pkg.sv
// Shared types, constants and AES helper functions for the address resolver.
`timescale 1ns / 1ps
package par_pkg;

  localparam int MaxKeysDefault = 16;

  localparam logic [1:0] EnableRun  = 2'd3;
  localparam logic [1:0] RandTag    = 2'b01;
  localparam int         AesRounds  = 10;

  localparam logic [1:0] RegEnable = 2'd0;
  localparam logic [1:0] RegKeyCount = 2'd1;
  localparam logic [1:0] RegIrqEnable = 2'd2;

  localparam logic ActLoad  = 1'b0;
  localparam logic ActStart = 1'b1;

  typedef struct packed {
    logic        action;
    logic [3:0]  key_index;
    logic [63:0] key_high;
    logic [63:0] key_low;
    logic [47:0] address;
  } in_word_t;

  typedef struct packed {
    logic       resolved;
    logic [3:0] status_index;
    logic [4:0] keys_checked;
    logic       interrupt;
  } out_word_t;

  // controller to datapath
  typedef struct packed {
    logic latch;      // capture address
    logic key_load;   // load key from table slot, state from plaintext and key
    logic round;      // run one AES round
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic match;
    logic last_round;
    logic resolvable;
  } dp_stat_t;

  function automatic logic [7:0] sbox(input logic [7:0] x);
    logic [7:0] t [256];
    t = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };
    return t[x];
  endfunction

  function automatic logic [7:0] xt(input logic [7:0] x);
    return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

endpackage

// File: rtl/par_aes_dp.sv
// Datapath: key table, AES-128 round unit with on-the-fly key schedule, hash compare.
`timescale 1ns / 1ps
module par_aes_dp import par_pkg::*; #(
  parameter int MaxKeys = MaxKeysDefault,
  parameter int IdxW = (MaxKeys > 1) ? $clog2(MaxKeys) : 1
) (
  input  logic            clk,
  input  logic            load_we,
  input  logic [IdxW-1:0] load_idx,
  input  logic [127:0]    load_key,
  input  logic [47:0]     addr_in,
  input  logic [IdxW-1:0] rd_idx,
  input  dp_cmd_t         cmd,
  output dp_stat_t        stat
);

  logic [127:0] key_mem [MaxKeys];
  logic [127:0] rd_key;
  logic [23:0]  hash;
  logic [23:0]  prand;
  logic [127:0] st;
  logic [127:0] rk;
  logic [7:0]   rcon;
  logic [3:0]   rnd;

  // bytes: index 0 is most significant byte
  logic [7:0] sb [16];
  logic [7:0] sr [16];
  logic [7:0] mc [16];
  logic [7:0] kw [16];
  logic [7:0] nk [16];
  logic [7:0] ns [16];
  logic [127:0] st_next;
  logic [127:0] rk_next;
  logic [127:0] pt;

  always_ff @(posedge clk) begin
    if (load_we) begin
      key_mem[load_idx] <= load_key;
    end
    rd_key <= key_mem[rd_idx];
  end

  assign pt = {104'd0, prand};

  always_comb begin
    for (int i = 0; i < 16; i++) begin
      kw[i] = rk[127-8*i -: 8];
      sb[i] = sbox(st[127-8*i -: 8]);
    end
    for (int c = 0; c < 4; c++) begin
      for (int i = 0; i < 4; i++) begin
        sr[i+4*c] = sb[i + 4*((c+i) & 3)];
      end
    end
    for (int c = 0; c < 4; c++) begin
      logic [7:0] x;
      x = sr[4*c] ^ sr[4*c+1] ^ sr[4*c+2] ^ sr[4*c+3];
      mc[4*c]   = sr[4*c]   ^ x ^ xt(sr[4*c]   ^ sr[4*c+1]);
      mc[4*c+1] = sr[4*c+1] ^ x ^ xt(sr[4*c+1] ^ sr[4*c+2]);
      mc[4*c+2] = sr[4*c+2] ^ x ^ xt(sr[4*c+2] ^ sr[4*c+3]);
      mc[4*c+3] = sr[4*c+3] ^ x ^ xt(sr[4*c+3] ^ sr[4*c]);
    end
    // next round key
    nk[0] = kw[0] ^ sbox(kw[13]) ^ rcon;
    nk[1] = kw[1] ^ sbox(kw[14]);
    nk[2] = kw[2] ^ sbox(kw[15]);
    nk[3] = kw[3] ^ sbox(kw[12]);
    for (int i = 4; i < 16; i++) begin
      nk[i] = kw[i] ^ nk[i-4];
    end
    for (int i = 0; i < 16; i++) begin
      ns[i] = ((rnd == 4'(AesRounds)) ? sr[i] : mc[i]) ^ nk[i];
      st_next[127-8*i -: 8] = ns[i];
      rk_next[127-8*i -: 8] = nk[i];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      hash  <= addr_in[23:0];
      prand <= addr_in[47:24];
    end
    if (cmd.key_load) begin
      st   <= pt ^ rd_key;
      rk   <= rd_key;
      rcon <= 8'h01;
      rnd  <= 4'd1;
    end else if (cmd.round) begin
      st   <= st_next;
      rk   <= rk_next;
      rcon <= xt(rcon);
      rnd  <= rnd + 4'd1;
    end
  end

  assign stat.match      = (st[23:0] == hash);
  assign stat.last_round = (rnd == 4'(AesRounds));
  assign stat.resolvable = (prand[23:22] == RandTag);

endmodule

// File: rtl/par_ctrl.sv
// Controller: sequences key fetch, ten AES rounds per key and the result word.
`timescale 1ns / 1ps
module par_ctrl import par_pkg::*; #(
  parameter int MaxKeys = MaxKeysDefault,
  parameter int IdxW = (MaxKeys > 1) ? $clog2(MaxKeys) : 1
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            go,
  input  logic [4:0]      key_count,
  input  logic [2:0]      irq_en,
  input  dp_stat_t        stat,
  output dp_cmd_t         cmd,
  output logic [IdxW-1:0] rd_idx,
  output logic            busy,
  output logic            done,
  output out_word_t       result
);

  typedef enum logic [2:0] {Idle, Check, Fetch, Seed, Rounds, Compare} state_t;
  state_t state;
  logic [6:0] tries;
  logic [6:0] cnt;
  logic [3:0] status;

  localparam logic [6:0] MaxK = 7'(MaxKeys);

  always_comb begin
    cmd.latch    = go;
    cmd.key_load = (state == Seed);
    cmd.round    = (state == Rounds);
  end

  assign rd_idx = cnt[IdxW-1:0];
  assign busy   = (state != Idle);

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= Idle;
      done   <= 1'b0;
      status <= 4'd0;
      cnt    <= '0;
      tries  <= '0;
      result <= '0;
    end else begin
      done <= 1'b0;
      unique case (state)
        Idle: begin
          if (go) begin
            tries <= ({2'b0, key_count} > MaxK) ? MaxK : {2'b0, key_count};
            cnt   <= '0;
            state <= Check;
          end
        end
        Check: begin
          if (!stat.resolvable || cnt == tries) begin
            result.resolved     <= 1'b0;
            result.status_index <= status;
            result.keys_checked <= tries[4:0];
            result.interrupt    <= irq_en[0] | irq_en[2];
            done  <= 1'b1;
            state <= Idle;
          end else begin
            state <= Fetch;
          end
        end
        Fetch:  state <= Seed;
        Seed:   state <= Rounds;
        Rounds: if (stat.last_round) state <= Compare;
        Compare: begin
          if (stat.match) begin
            status              <= cnt[3:0];
            result.resolved     <= 1'b1;
            result.status_index <= cnt[3:0];
            result.keys_checked <= 5'(cnt + 7'd1);
            result.interrupt    <= irq_en[0] | irq_en[1];
            done  <= 1'b1;
            state <= Idle;
          end else begin
            cnt   <= cnt + 7'd1;
            state <= Check;
          end
        end
        default: state <= Idle;
      endcase
    end
  end

  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> state == Idle)
    else $error("done outside idle");
  a_cnt_range: assert property (@(posedge clk) disable iff (rst) cnt <= tries)
    else $error("key counter overran");
  a_go_busy: assert property (@(posedge clk) disable iff (rst) go |=> busy)
    else $error("start not taken");

endmodule

// File: rtl/private_address_resolver_unit.sv
// Top level of the private address resolver.
// Timing: a start word steps through Check and, for each key tried, Fetch, Seed,
//   Rounds and Compare; its result is registered from Check when the address is
//   unresolvable or no keys remain, else from Compare on a match.
// Throughput: one start word at a time; one AES round per cycle in a single round
//   unit. Load and ignored starts never set busy. Reset (rst, synchronous): control
//   and config registers and stored status clear; the key table and datapath do not.
`timescale 1ns / 1ps
module private_address_resolver_unit import par_pkg::*; #(
  parameter int MaxKeys = MaxKeysDefault
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  in_word_t   in_word,
  output logic       done,
  output out_word_t  out_word,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [4:0] cfg_data
);

  localparam int IdxW = (MaxKeys > 1) ? $clog2(MaxKeys) : 1;

  logic [1:0] enable;
  logic [4:0] key_count;
  logic [2:0] irq_en;
  logic       accept;
  logic       go;
  logic       load_we;
  logic [IdxW-1:0] rd_idx;
  logic [IdxW-1:0] load_idx;
  dp_cmd_t    cmd;
  dp_stat_t   stat;

  assign cfg_ready = 1'b1;
  assign accept  = start && !busy;
  assign go      = accept && in_word.action == ActStart && enable == EnableRun;
  assign load_we = accept && in_word.action == ActLoad &&
                   (32'(in_word.key_index) < MaxKeys);
  assign load_idx = IdxW'(in_word.key_index);

  always_ff @(posedge clk) begin
    if (rst) begin
      enable    <= '0;
      key_count <= '0;
      irq_en    <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        RegEnable:    enable    <= cfg_data[1:0];
        RegKeyCount:  key_count <= cfg_data;
        RegIrqEnable: irq_en    <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  par_aes_dp #(.MaxKeys(MaxKeys), .IdxW(IdxW)) u_dp (
    .clk, .load_we,
    .load_idx,
    .load_key({in_word.key_high, in_word.key_low}),
    .addr_in(in_word.address),
    .rd_idx, .cmd, .stat
  );

  par_ctrl #(.MaxKeys(MaxKeys), .IdxW(IdxW)) u_ctrl (
    .clk, .rst, .go, .key_count, .irq_en, .stat, .cmd, .rd_idx,
    .busy, .done, .result(out_word)
  );

endmodule

// File: bench/testbench.sv
// Self-checking testbench for the private address resolver unit.
`timescale 1ns / 1ps
module testbench;
  import par_pkg::*;

  typedef enum logic {RowCfg, RowWord} row_kind_t;

  typedef struct {
    row_kind_t  kind;
    logic [1:0] idx;
    logic [4:0] data;
    in_word_t   w;
    int         match_slot;  // >= 0: hash is made to match this slot
    bit         typed;
    out_word_t  want;
  } stim_row_t;

  logic       clk;
  logic       rst;
  logic       start;
  logic       busy;
  in_word_t   in_word;
  logic       done;
  out_word_t  out_word;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [1:0] cfg_index;
  logic [4:0] cfg_data;

  private_address_resolver_unit u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .in_word(in_word),
    .done(done), .out_word(out_word), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // resolver state as the block should hold it
  logic [63:0] key_hi [MaxKeysDefault];
  logic [63:0] key_lo [MaxKeysDefault];
  logic [3:0]  match_idx;
  logic [1:0]  en_reg;
  logic [4:0]  kcount_reg;
  logic [2:0]  irq_reg;
  logic [7:0]  sub_tab [256];

  out_word_t   pending_results [$];
  stim_row_t   rows [$];
  bit          typed_next;
  out_word_t   typed_want;
  int          n_items, n_results, n_hits, n_misses, n_loads, n_ignored, n_mism, n_cfg;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] p;
    p = 8'h00;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) p ^= a;
      a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    end
    return p;
  endfunction

  // S-box from the field inverse and the affine map
  function automatic void build_sub_tab();
    logic [7:0] inv, b;
    for (int x = 0; x < 256; x++) begin
      inv = 8'h01;
      for (int e = 0; e < 254; e++) inv = gf_mul(inv, 8'(x));
      b = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]} ^ {inv[4:0], inv[7:5]}
          ^ {inv[3:0], inv[7:4]} ^ 8'h63;
      sub_tab[x] = b;
    end
  endfunction

  function automatic logic [7:0] dbl(input logic [7:0] x);
    return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  // AES-128, byte 0 in the top bits of key, plaintext and ciphertext
  function automatic logic [127:0] aes_encrypt(input logic [127:0] key, input logic [127:0] pt);
    logic [7:0]   w [176];
    logic [7:0]   s [16];
    logic [7:0]   t [16];
    logic [7:0]   a0, a1, a2, a3, h, x, p0, rc;
    logic [127:0] ct;
    rc = 8'h01;
    for (int i = 0; i < 16; i++) w[i] = key[127 - 8 * i -: 8];
    for (int i = 16; i < 176; i += 4) begin
      a0 = w[i - 4]; a1 = w[i - 3]; a2 = w[i - 2]; a3 = w[i - 1];
      if (i % 16 == 0) begin
        h = a0;
        a0 = sub_tab[a1] ^ rc;
        a1 = sub_tab[a2];
        a2 = sub_tab[a3];
        a3 = sub_tab[h];
        rc = dbl(rc);
      end
      w[i] = w[i - 16] ^ a0;
      w[i + 1] = w[i - 15] ^ a1;
      w[i + 2] = w[i - 14] ^ a2;
      w[i + 3] = w[i - 13] ^ a3;
    end
    for (int i = 0; i < 16; i++) s[i] = pt[127 - 8 * i -: 8] ^ w[i];
    for (int r = 1; r <= 10; r++) begin
      for (int c = 0; c < 4; c++)
        for (int i = 0; i < 4; i++) t[i + 4 * c] = sub_tab[s[i + 4 * ((c + i) % 4)]];
      if (r != 10) begin
        for (int c = 0; c < 4; c++) begin
          x = t[4 * c] ^ t[4 * c + 1] ^ t[4 * c + 2] ^ t[4 * c + 3];
          p0 = t[4 * c];
          t[4 * c]     = t[4 * c]     ^ x ^ dbl(t[4 * c] ^ t[4 * c + 1]);
          t[4 * c + 1] = t[4 * c + 1] ^ x ^ dbl(t[4 * c + 1] ^ t[4 * c + 2]);
          t[4 * c + 2] = t[4 * c + 2] ^ x ^ dbl(t[4 * c + 2] ^ t[4 * c + 3]);
          t[4 * c + 3] = t[4 * c + 3] ^ x ^ dbl(t[4 * c + 3] ^ p0);
        end
      end
      for (int i = 0; i < 16; i++) s[i] = t[i] ^ w[16 * r + i];
    end
    for (int i = 0; i < 16; i++) ct[127 - 8 * i -: 8] = s[i];
    return ct;
  endfunction

  function automatic logic [23:0] rpa_hash(input int slot, input logic [23:0] prand);
    logic [127:0] ct;
    ct = aes_encrypt({key_hi[slot], key_lo[slot]}, {104'd0, prand});
    return ct[23:0];
  endfunction

  function automatic int slots_tried();
    return (kcount_reg > MaxKeysDefault) ? MaxKeysDefault : int'(kcount_reg);
  endfunction

  // update the state for one accepted word; returns 1 when a result is due
  function automatic bit resolve_word(input in_word_t w, output out_word_t r);
    int   tries, checked;
    bit   hit;
    r = '0;
    if (w.action == ActLoad) begin
      key_hi[w.key_index] = w.key_high;
      key_lo[w.key_index] = w.key_low;
      return 1'b0;
    end
    if (en_reg != EnableRun) return 1'b0;
    tries = slots_tried();
    checked = tries;
    hit = 1'b0;
    if (w.address[47:46] == RandTag) begin
      for (int i = 0; i < tries; i++) begin
        if (!hit && rpa_hash(i, w.address[47:24]) == w.address[23:0]) begin
          hit = 1'b1;
          match_idx = 4'(i);
          checked = i + 1;
        end
      end
    end
    r.resolved = hit;
    r.status_index = match_idx;
    r.keys_checked = 5'(checked);
    r.interrupt = irq_reg[0] || (hit && irq_reg[1]) || (!hit && irq_reg[2]);
    return 1'b1;
  endfunction

  // accepted words and register writes
  always @(posedge clk) begin
    out_word_t r;
    if (!rst) begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          RegEnable:    en_reg <= cfg_data[1:0];
          RegKeyCount:  kcount_reg <= cfg_data;
          RegIrqEnable: irq_reg <= cfg_data[2:0];
          default: ;
        endcase
      end
      if (start && !busy) begin
        if (resolve_word(in_word, r)) begin
          pending_results.push_back(typed_next ? typed_want : r);
          if (r.resolved) n_hits++;
          else n_misses++;
        end else if (in_word.action == ActLoad) begin
          n_loads++;
        end else begin
          n_ignored++;
        end
        typed_next = 1'b0;
      end
    end
  end

  // compare each result word with the oldest expectation
  always @(posedge clk) begin
    out_word_t want;
    if (!rst && done) begin
      n_results++;
      if (pending_results.size() == 0) begin
        n_mism++;
        if (n_mism <= 10) $display("unexpected result word %h", out_word);
      end else begin
        want = pending_results.pop_front();
        if (out_word.resolved !== want.resolved || out_word.status_index !== want.status_index
            || out_word.keys_checked !== want.keys_checked
            || out_word.interrupt !== want.interrupt) begin
          n_mism++;
          if (n_mism <= 10)
            $display("mismatch: expected res=%0d idx=%0d chk=%0d irq=%0d, got %0d %0d %0d %0d",
                     want.resolved, want.status_index, want.keys_checked, want.interrupt,
                     out_word.resolved, out_word.status_index, out_word.keys_checked,
                     out_word.interrupt);
        end
      end
    end
  end

  task automatic write_reg(input logic [1:0] idx, input logic [4:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    n_cfg++;
  endtask

  // hold off until every result is in and the block has settled
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (240) @(posedge clk);
  endtask

  task automatic send_word(input in_word_t w);
    int gap;
    gap = $urandom_range(0, 13);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    if (w.action == ActLoad || en_reg == EnableRun) n_items++;
    start <= 1'b1;
    in_word <= w;
    do @(posedge clk); while (busy);
  endtask

  function automatic in_word_t rand_word();
    in_word_t w;
    w.action = 1'($urandom);
    w.key_index = 4'($urandom);
    w.key_high = {$urandom, $urandom};
    w.key_low = {$urandom, $urandom};
    w.address = {16'($urandom), $urandom};
    return w;
  endfunction

  function automatic void add_cfg(input logic [1:0] idx, input logic [4:0] data);
    stim_row_t row;
    row = '{kind: RowCfg, idx: idx, data: data, w: '0, match_slot: -1, typed: 0, want: '0};
    rows.push_back(row);
  endfunction

  function automatic void add_word(input in_word_t w, input int slot, input bit typed,
                                   input out_word_t want);
    stim_row_t row;
    row = '{kind: RowWord, idx: '0, data: '0, w: w, match_slot: slot, typed: typed,
            want: want};
    rows.push_back(row);
  endfunction

  initial begin
    in_word_t   w;
    logic [23:0] prand;
    int         slot, burst, pick;
    start = 1'b0;
    in_word = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    rst = 1'b1;
    typed_next = 1'b0;
    match_idx = '0;
    en_reg = '0;
    kcount_reg = '0;
    irq_reg = '0;
    build_sub_tab();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed rows: ignored start, zero keys, table fill, extremes, matches
    w = '0;
    w.action = ActStart;
    w.address = {24'h400000, 24'h000000};
    add_word(w, -1, 0, '0);
    add_cfg(RegEnable, 5'd3);
    w.address = '0;
    add_word(w, -1, 1, '{resolved: 0, status_index: 0, keys_checked: 0, interrupt: 0});
    w.address = '1;
    add_word(w, -1, 1, '{resolved: 0, status_index: 0, keys_checked: 0, interrupt: 0});
    for (int i = 0; i < MaxKeysDefault; i++) begin
      w = rand_word();
      w.action = ActLoad;
      w.key_index = 4'(i);
      if (i == 0) {w.key_high, w.key_low} = '0;
      if (i == MaxKeysDefault - 1) {w.key_high, w.key_low} = '1;
      add_word(w, -1, 0, '0);
    end
    add_cfg(RegKeyCount, 5'd16);
    add_cfg(RegIrqEnable, 5'd7);
    w = '0;
    w.action = ActStart;
    w.address = {24'hC00000, 24'h123456};
    add_word(w, -1, 1, '{resolved: 0, status_index: 0, keys_checked: 16, interrupt: 1});
    w.address = {24'h7FFFFF, 24'h0};
    add_word(w, 15, 0, '0);
    w.address = {24'h400000, 24'h0};
    add_word(w, 0, 0, '0);
    add_cfg(RegKeyCount, 5'd31);
    add_cfg(RegIrqEnable, 5'd2);
    add_cfg(2'd3, 5'd31);
    w.address = {24'h400001, 24'hFFFFFF};
    add_word(w, -1, 1, '{resolved: 0, status_index: 0, keys_checked: 16, interrupt: 0});
    w.address = {24'h5A5A5A, 24'h0};
    add_word(w, 7, 0, '0);

    foreach (rows[i]) begin
      if (rows[i].kind == RowCfg) begin
        drain();
        write_reg(rows[i].idx, rows[i].data);
      end else begin
        w = rows[i].w;
        if (rows[i].match_slot >= 0)
          w.address[23:0] = rpa_hash(rows[i].match_slot, w.address[47:24]);
        typed_next = rows[i].typed;
        typed_want = rows[i].want;
        send_word(w);
      end
    end

    // random phases, each under its own register setting
    while (n_items < 1550) begin
      drain();
      case ($urandom_range(0, 9))
        0: write_reg(RegEnable, 5'($urandom_range(0, 2)));
        1: write_reg(RegEnable, 5'd31);
        default: write_reg(RegEnable, 5'd3);
      endcase
      case ($urandom_range(0, 7))
        0: write_reg(RegKeyCount, 5'd0);
        1: write_reg(RegKeyCount, 5'd1);
        2: write_reg(RegKeyCount, 5'd16);
        3: write_reg(RegKeyCount, 5'($urandom_range(17, 31)));
        default: write_reg(RegKeyCount, 5'($urandom_range(1, 15)));
      endcase
      write_reg(RegIrqEnable, 5'($urandom));
      if ($urandom_range(0, 7) == 0) write_reg(2'd3, 5'($urandom));
      burst = $urandom_range(30, 80);
      for (int k = 0; k < burst; k++) begin
        w = rand_word();
        pick = $urandom_range(0, 99);
        prand = {2'b01, 22'($urandom)};
        if (pick < 12) begin
          w.action = ActLoad;
        end else begin
          w.action = ActStart;
          if (pick < 72 && slots_tried() > 0) begin
            slot = $urandom_range(0, slots_tried() + 1);
            if (slot > MaxKeysDefault - 1) slot = MaxKeysDefault - 1;
            w.address = {prand, rpa_hash(slot, prand)};
          end else if (pick < 86) begin
            w.address[47:24] = prand;
          end
        end
        send_word(w);
      end
    end

    start <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (240) @(posedge clk);
    $display("covered %0d words: %0d loads, %0d ignored starts, %0d register writes",
             n_items + n_ignored, n_loads, n_ignored, n_cfg);
    $display("results checked %0d: %0d resolved, %0d not resolved, %0d mismatches",
             n_results, n_hits, n_misses, n_mism);
    if (n_mism == 0 && pending_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #40ms;
    $display("timeout waiting for the resolver");
    $display("*** FAILED ***");
    $finish;
  end

endmodule

// File: private_address_resolver_unit.f
rtl/par_pkg.sv
rtl/par_aes_dp.sv
rtl/par_ctrl.sv
rtl/private_address_resolver_unit.sv
bench/testbench.sv
